// ===== rtl/core/tbe_pkg.sv =====
package tbe_pkg;

   // Fixed widths of the arithmetic.
   localparam int unsigned WORD_W = 32;
   localparam int unsigned CNT_W = $clog2(WORD_W);
   localparam int unsigned EXP_W = 5;

   // Scaling constants of the timing computation.
   localparam logic [19:0] US_PER_MS = 20'd1000;
   localparam logic [19:0] BUDGET_OFFSET_US = 20'd2500;
   localparam logic [WORD_W-1:0] OSC_NUMERATOR = 32'h4000_0000;
   localparam logic [11:0] MACRO_SCALE = 12'd2304;
   localparam logic [4:0] PERIODS_A = 5'd16;
   localparam logic [4:0] PERIODS_B = 5'd12;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OSC_DIV,
      ST_PERIOD,
      ST_LAUNCH,
      ST_QUOT_DIV,
      ST_NORM,
      ST_RESPOND
   } tbe_state_type;

   // Request into the shared divider.
   typedef struct packed {
      logic start;
      logic [WORD_W-1:0] dividend;
      logic [WORD_W-1:0] divisor;
   } tbe_div_req_type;

   // Answer from the shared divider.
   typedef struct packed {
      logic done;
      logic [WORD_W-1:0] quotient;
   } tbe_div_rsp_type;

endpackage

// ===== rtl/core/tbe_divider.sv =====
module tbe_divider
   import tbe_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  tbe_div_req_type div_req,
   output tbe_div_rsp_type div_rsp
);

   logic run_ff, run_in;
   logic done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [WORD_W-1:0] dvs_ff, dvs_in;
   logic [WORD_W:0] shifted;
   logic [WORD_W:0] diff;
   logic take;

   // One restoring step: bring down the next dividend bit and try the subtract.
   // A zero divisor always subtracts, so the quotient comes out all ones.
   always_comb begin
      shifted = {rem_ff, quo_ff[WORD_W-1]};
      diff = shifted - {1'b0, dvs_ff};
      take = (shifted >= {1'b0, dvs_ff});
   end

   // Next values of the iteration registers.
   always_comb begin
      run_in = run_ff;
      done_in = 1'b0;
      count_in = count_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      if (div_req.start) begin
         run_in = 1'b1;
         count_in = CNT_W'(WORD_W - 1);
         rem_in = '0;
         quo_in = div_req.dividend;
         dvs_in = div_req.divisor;
      end else if (run_ff) begin
         rem_in = take ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
         quo_in = {quo_ff[WORD_W-2:0], take};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== rtl/core/tof_timing_budget_encoder.sv =====
// Timing budget encoder for a time-of-flight ranging sensor.
//
// Input channel: a beat is taken at a rising edge with start high and busy
// low. It carries the oscillator frequency word and the timing budget in ms.
// Result channel: rsp_strobe is high for exactly one cycle per input beat,
// with rsp_status and the two encoded timing words valid in that cycle. The
// receiver cannot stall, so the result is simply taken at the end of it.
//
// Sequencing: a rejected beat (oscillator word zero or budget of 2 ms or less)
// answers in the cycle after it is taken. Any other beat makes three 32-step
// passes through the one shared restoring divider (one quotient bit per cycle)
// and then normalizes each word by single right shifts (up to 24 each). The
// block takes no new beat until the result has been shown.
//
// Reset (synchronous, active high) returns the sequencer to idle and drops
// any beat in progress; no result is shown for it.
module tof_timing_budget_encoder
   import tbe_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [15:0] req_osc_freq,
   input  logic [9:0] req_budget_ms,
   output logic rsp_strobe,
   output logic rsp_status,
   output logic [15:0] rsp_timing_word_a,
   output logic [15:0] rsp_timing_word_b
);

   tbe_state_type state_ff, state_in;
   tbe_div_req_type div_req;
   tbe_div_rsp_type div_rsp;

   logic sel_b_ff;
   logic status_ff;
   logic [WORD_W-1:0] budget_ff;
   logic [WORD_W-1:0] macro_ff;
   logic [WORD_W-1:0] divisor_ff;
   logic [WORD_W-1:0] val_ff;
   logic [EXP_W-1:0] exp_ff;
   logic [15:0] word_a_ff;
   logic [15:0] word_b_ff;

   logic [19:0] budget_us;
   logic reject;
   logic norm_more;
   logic [WORD_W-1:0] period;
   logic [15:0] word_enc;
   logic [WORD_W+11:0] macro_prod;

   // Input checks and the scaled budget in microseconds.
   always_comb begin
      budget_us = 20'(req_budget_ms) * US_PER_MS;
      reject = (req_osc_freq == '0) || (budget_us <= BUDGET_OFFSET_US);
   end

   // Full-width product of the oscillator quotient and the macro scale.
   always_comb begin
      macro_prod = (WORD_W + 12)'(div_rsp.quotient) * (WORD_W + 12)'(MACRO_SCALE);
   end

   // Period for the word in progress, and the encoded word from the normalizer.
   always_comb begin
      if (sel_b_ff) begin
         period = WORD_W'(macro_ff * PERIODS_B);
      end else begin
         period = WORD_W'(macro_ff * PERIODS_A);
      end
      norm_more = (val_ff[WORD_W-1:8] != '0);
      word_enc = {{(8 - EXP_W){1'b0}}, exp_ff, val_ff[7:0]};
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = reject ? ST_RESPOND : ST_OSC_DIV;
            end
         end
         ST_OSC_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_PERIOD;
            end
         end
         ST_PERIOD: begin
            state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            state_in = ST_QUOT_DIV;
         end
         ST_QUOT_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (!norm_more) begin
               state_in = sel_b_ff ? ST_RESPOND : ST_PERIOD;
            end
         end
         ST_RESPOND: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Handshake outputs and the divider request.
   always_comb begin
      busy = (state_ff != ST_IDLE);
      rsp_strobe = (state_ff == ST_RESPOND);
      div_req.start = 1'b0;
      div_req.dividend = budget_ff + (divisor_ff >> 1);
      div_req.divisor = divisor_ff;
      case (state_ff)
         ST_IDLE: begin
            div_req.start = start && !reject;
            div_req.dividend = OSC_NUMERATOR;
            div_req.divisor = WORD_W'(req_osc_freq);
         end
         ST_LAUNCH: begin
            div_req.start = 1'b1;
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_b_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_IDLE) begin
            sel_b_ff <= 1'b0;
         end else if (state_ff == ST_NORM && !norm_more) begin
            sel_b_ff <= 1'b1;
         end
      end
   end

   // Datapath registers, loaded as the sequencer walks through the steps.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               status_ff <= reject;
               word_a_ff <= '0;
               word_b_ff <= '0;
               budget_ff <= {budget_us - BUDGET_OFFSET_US, 12'b0};
            end
         end
         ST_OSC_DIV: begin
            if (div_rsp.done) begin
               macro_ff <= macro_prod[WORD_W+5:6];
            end
         end
         ST_PERIOD: begin
            divisor_ff <= period >> 6;
         end
         ST_QUOT_DIV: begin
            if (div_rsp.done) begin
               val_ff <= div_rsp.quotient - 1'b1;
               exp_ff <= '0;
            end
         end
         ST_NORM: begin
            // Halve until only the low byte can be set; count the halvings.
            if (norm_more) begin
               val_ff <= val_ff >> 1;
               exp_ff <= exp_ff + 1'b1;
            end else if (sel_b_ff) begin
               word_b_ff <= word_enc;
            end else begin
               word_a_ff <= word_enc;
            end
         end
         default: begin
         end
      endcase
   end

   tbe_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_status = status_ff;
   assign rsp_timing_word_a = word_a_ff;
   assign rsp_timing_word_b = word_b_ff;

endmodule

// ===== rtl/core/tbe_checker.sv =====
module tbe_checker
   import tbe_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic [15:0] req_osc_freq,
   input logic [9:0] req_budget_ms,
   input logic rsp_strobe,
   input logic rsp_status,
   input logic [15:0] rsp_timing_word_a,
   input logic [15:0] rsp_timing_word_b
);

   // A result only appears while a beat is being worked on.
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   // One result per beat, and the block is free right after it.
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe && !busy)
      else $error("result strobe not followed by idle");

   // A rejected pair carries zero words.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status |->
         rsp_timing_word_a == 16'd0 && rsp_timing_word_b == 16'd0)
      else $error("rejected result with nonzero words");

   // A zero oscillator word is answered as rejected in the next cycle.
   a_zero_osc: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_osc_freq == 16'd0 |=> rsp_strobe && rsp_status)
      else $error("zero oscillator word not rejected at once");

   // The exponent never exceeds the width of a 32-bit word minus the mantissa.
   a_exp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_timing_word_a[15:8] <= 8'd24 && rsp_timing_word_b[15:8] <= 8'd24)
      else $error("timing word exponent out of range");

endmodule

bind tof_timing_budget_encoder tbe_checker u_tbe_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_osc_freq      (req_osc_freq),
   .req_budget_ms     (req_budget_ms),
   .rsp_strobe        (rsp_strobe),
   .rsp_status        (rsp_status),
   .rsp_timing_word_a (rsp_timing_word_a),
   .rsp_timing_word_b (rsp_timing_word_b)
);
